// ----- src/crout_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package crout_pkg;
    localparam int unsigned DefMaxOrder = 8;
    localparam int unsigned CfgW = 4;

    typedef struct packed {
        logic signed [31:0] coefficient;
        logic               last_coefficient;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] solution_value;
        logic [2:0]         unknown_index;
        logic               singular;
        logic               last_solution;
    } t_out_req;

    typedef enum logic [3:0] {
        S_LOAD, S_FILL, S_LCOL, S_LACC, S_LWR, S_PIV, S_UACC, S_UDIV,
        S_BINIT, S_BACC, S_BWR, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE, OP_MAC, OP_DIV
    } t_op;

    typedef struct packed {
        t_op  op;
        logic acc_load;
    } t_cmd;

    typedef struct packed {
        logic busy_dp;
        logic acc_zero_flag;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- src/crout_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module crout_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- src/crout_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Arithmetic unit: registered multiply, saturating accumulate, serial divider.
module crout_dp import crout_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    input  wire logic signed [31:0] i_init,
    output t_sts                    o_sts,
    output logic signed [31:0]      o_acc
);
    logic signed [31:0] r_acc;
    logic signed [63:0] r_prod;
    logic               r_pv;
    logic [5:0]         r_cnt;
    logic               r_dbusy;
    logic               r_neg;
    logic [47:0]        r_num;
    logic [31:0]        r_den;
    logic [32:0]        r_rem;
    logic [47:0]        r_quo;
    logic signed [63:0] prod_sh;
    logic signed [32:0] a_abs;
    logic signed [32:0] b_abs;
    logic [32:0]        rem_sh;
    logic signed [49:0] q_s;

    function automatic logic signed [32:0] i_acc_abs(input logic signed [31:0] v);
        return v[31] ? -33'(v) : 33'(v);
    endfunction

    always_comb begin
        // floor shift of the product
        prod_sh = r_prod >>> 16;
        a_abs = i_acc_abs(r_acc);
        b_abs = i_acc_abs(i_b);
        rem_sh = {r_rem[31:0], r_num[47]};
        q_s = r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_dbusy <= 1'b0;
        end else begin
            r_pv <= (i_cmd.op == OP_MAC);
            if (i_cmd.op == OP_MAC) r_prod <= i_a * i_b;
            if (i_cmd.acc_load) r_acc <= i_init;
            else if (r_pv)
                r_acc <= sat32(66'(r_acc) - 66'(sat32(66'(prod_sh))));
            if (i_cmd.op == OP_DIV) begin
                r_dbusy <= 1'b1;
                r_cnt <= 6'd48;
                r_neg <= r_acc[31] ^ i_b[31];
                r_num <= {a_abs[31:0], 16'b0};
                r_den <= b_abs[31:0];
                r_rem <= '0;
                r_quo <= '0;
            end else if (r_dbusy) begin
                if (r_cnt == 6'd0) begin
                    r_dbusy <= 1'b0;
                    r_acc <= sat32(66'(q_s));
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                    r_num <= r_num << 1;
                    if (rem_sh >= {1'b0, r_den}) begin
                        r_rem <= rem_sh - {1'b0, r_den};
                        r_quo <= {r_quo[46:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[46:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_acc = r_acc;
    assign o_sts.busy_dp = r_dbusy | r_pv | (i_cmd.op != OP_NONE);
    assign o_sts.acc_zero_flag = (r_acc == 32'sd0);
endmodule
`default_nettype wire

// ----- src/crout_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: load, Crout factorisation, back substitution, emit.
module crout_ctrl import crout_pkg::*; #(
    parameter int unsigned MaxOrder = DefMaxOrder
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire t_in_req                     i_req,
    input  wire logic                        i_cfg_we,
    input  wire logic [CfgW-1:0]             i_cfg_data,
    input  wire t_sts                        i_sts,
    input  wire logic signed [31:0]          i_acc,
    output t_cmd                             o_cmd,
    output logic signed [31:0]               o_a,
    output logic signed [31:0]               o_b,
    output logic signed [31:0]               o_init,
    output logic                             o_busy,
    output logic                             o_valid,
    output t_out_req                         o_res
);
    localparam int unsigned Cols = MaxOrder + 1;
    localparam int unsigned MDepth = MaxOrder * Cols;
    localparam int unsigned AW = $clog2(MDepth);
    localparam int unsigned IW = $clog2(MaxOrder + 1);
    localparam int unsigned CW = $clog2(Cols + 1);
    localparam int unsigned SW = $clog2(MaxOrder);

    t_state r_state, n_state;
    logic [CfgW-1:0] r_order;
    logic [IW-1:0]   nn;
    logic [CW-1:0]   r_row, n_row, r_col, n_col;
    logic [IW-1:0]   r_p, n_p, r_i, n_i, r_k, n_k;
    logic            r_sing, n_sing, r_ph, n_ph;
    logic [1:0]      r_sub, n_sub;

    // A = work, U = upper (same shape), L = lower, X = solution
    logic            w_we, u_we, l_we, x_we;
    logic [AW-1:0]   w_wa, w_ra, u_wa, u_ra, l_wa, l_ra;
    logic [SW-1:0]   x_wa, x_ra;
    logic [31:0]     w_wd, w_rd, u_rd, l_rd, x_rd;

    crout_ram #(.Width(32), .Depth(MDepth)) u_w (.i_clk, .i_we(w_we), .i_waddr(w_wa),
        .i_wdata(w_wd), .i_raddr(w_ra), .o_rdata(w_rd));
    crout_ram #(.Width(32), .Depth(MDepth)) u_u (.i_clk, .i_we(u_we), .i_waddr(u_wa),
        .i_wdata(i_acc), .i_raddr(u_ra), .o_rdata(u_rd));
    crout_ram #(.Width(32), .Depth(MDepth)) u_l (.i_clk, .i_we(l_we), .i_waddr(l_wa),
        .i_wdata(i_acc), .i_raddr(l_ra), .o_rdata(l_rd));
    crout_ram #(.Width(32), .Depth(MaxOrder)) u_x (.i_clk, .i_we(x_we), .i_waddr(x_wa),
        .i_wdata(r_sing ? 32'd0 : i_acc), .i_raddr(x_ra), .o_rdata(x_rd));

    function automatic logic [AW-1:0] adr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(32'(r) * Cols + 32'(c));
    endfunction

    always_comb begin
        if (r_order == '0) nn = IW'(1);
        else if (32'(r_order) > MaxOrder) nn = IW'(MaxOrder);
        else nn = IW'(r_order);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_order <= CfgW'(3);
            r_row <= '0; r_col <= '0;
            r_p <= '0; r_i <= '0; r_k <= '0;
            r_sing <= 1'b0; r_ph <= 1'b0; r_sub <= '0;
        end else begin
            r_state <= n_state;
            r_row <= n_row; r_col <= n_col;
            r_p <= n_p; r_i <= n_i; r_k <= n_k;
            r_sing <= n_sing; r_ph <= n_ph; r_sub <= n_sub;
            if (i_cfg_we) begin
                r_order <= i_cfg_data;
                r_row <= '0; r_col <= '0;
            end
        end
    end

    // r_sub sequences: 0 issue read, 1 data ready / issue mac, 2 wait product
    always_comb begin
        n_state = r_state; n_row = r_row; n_col = r_col;
        n_p = r_p; n_i = r_i; n_k = r_k; n_sing = r_sing; n_ph = r_ph; n_sub = r_sub;
        o_cmd = '{op: OP_NONE, acc_load: 1'b0};
        o_a = $signed(l_rd); o_b = $signed(u_rd); o_init = $signed(w_rd);
        w_we = 1'b0; w_wa = adr(r_row, r_col); w_wd = i_req.coefficient;
        w_ra = '0; u_ra = '0; l_ra = '0; x_ra = '0;
        u_we = 1'b0; l_we = 1'b0; x_we = 1'b0;
        u_wa = '0; l_wa = '0; x_wa = '0;
        o_busy = 1'b1; o_valid = 1'b0;
        o_res = '{solution_value: $signed(x_rd), unknown_index: 3'(r_k),
                  singular: r_sing, last_solution: (r_k == nn - IW'(1))};
        unique case (r_state)
            S_LOAD: begin
                o_busy = 1'b0;
                if (i_start) begin
                    w_we = 1'b1;
                    if (r_col == CW'(nn)) begin
                        n_col = '0; n_row = r_row + CW'(1);
                    end else n_col = r_col + CW'(1);
                    if ((r_col == CW'(nn) && r_row == CW'(nn) - CW'(1)))
                        n_state = S_LCOL;
                    else if (i_req.last_coefficient) begin
                        n_state = S_FILL;
                    end
                    n_p = '0; n_i = '0; n_k = '0; n_sing = 1'b0; n_sub = '0; n_ph = 1'b0;
                end
            end
            S_FILL: begin
                w_we = 1'b1; w_wd = '0;
                if (r_col == CW'(nn)) begin
                    n_col = '0; n_row = r_row + CW'(1);
                end else n_col = r_col + CW'(1);
                if (r_col == CW'(nn) && r_row == CW'(nn) - CW'(1)) n_state = S_LCOL;
            end
            // column p of L for row i: acc = A[i][p] - sum L[i][k]*U[k][p]
            S_LCOL: begin
                n_row = '0; n_col = '0;
                w_ra = adr(CW'(r_i), CW'(r_p));
                n_sub = '0; n_k = '0;
                n_state = S_LACC;
                n_ph = 1'b0;
            end
            S_LACC: begin
                l_ra = adr(CW'(r_i), CW'(r_k));
                u_ra = adr(CW'(r_k), CW'(r_p));
                if (!r_ph) begin
                    o_cmd.acc_load = 1'b1; n_ph = 1'b1; n_sub = '0;
                end else if (r_k == r_p) begin
                    if (!i_sts.busy_dp) n_state = S_LWR;
                end else if (r_sub == 2'd0) n_sub = 2'd1;
                else if (r_sub == 2'd1) begin
                    o_cmd.op = OP_MAC; n_sub = 2'd2;
                end else if (!i_sts.busy_dp) begin
                    n_k = r_k + IW'(1); n_sub = '0;
                end
            end
            S_LWR: begin
                l_we = 1'b1; l_wa = adr(CW'(r_i), CW'(r_p));
                if (r_i == r_p && i_sts.acc_zero_flag) begin
                    n_sing = 1'b1; n_state = S_BINIT; n_k = '0;
                end else if (r_i == nn - IW'(1)) begin
                    n_state = S_PIV; n_i = r_p + IW'(1);
                    n_ph = 1'b0; n_k = '0; n_sub = '0;
                end else begin
                    n_i = r_i + IW'(1); n_state = S_LCOL;
                end
            end
            // row p of U, column j held in r_i
            S_PIV: begin
                w_ra = adr(CW'(r_p), CW'(r_i));
                n_state = S_UACC; n_ph = 1'b0; n_k = '0; n_sub = '0;
            end
            S_UACC: begin
                l_ra = adr(CW'(r_p), CW'(r_k));
                u_ra = adr(CW'(r_k), CW'(r_i));
                if (!r_ph) begin
                    o_cmd.acc_load = 1'b1; n_ph = 1'b1;
                end else if (r_k == r_p) begin
                    if (!i_sts.busy_dp) begin
                        l_ra = adr(CW'(r_p), CW'(r_p));
                        n_state = S_UDIV; n_sub = '0;
                    end
                end else if (r_sub == 2'd0) n_sub = 2'd1;
                else if (r_sub == 2'd1) begin
                    o_cmd.op = OP_MAC; n_sub = 2'd2;
                end else if (!i_sts.busy_dp) begin
                    n_k = r_k + IW'(1); n_sub = '0;
                end
            end
            S_UDIV: begin
                l_ra = adr(CW'(r_p), CW'(r_p));
                o_b = $signed(l_rd);
                if (r_sub == 2'd0) begin
                    o_cmd.op = OP_DIV; n_sub = 2'd1;
                end else if (!i_sts.busy_dp) begin
                    u_we = 1'b1; u_wa = adr(CW'(r_p), CW'(r_i));
                    if (CW'(r_i) == CW'(nn)) begin
                        if (r_p == nn - IW'(1)) begin
                            n_state = S_BINIT; n_k = nn - IW'(1);
                        end else begin
                            n_p = r_p + IW'(1); n_i = r_p + IW'(1); n_state = S_LCOL;
                        end
                    end else begin
                        n_i = r_i + IW'(1); n_state = S_PIV;
                    end
                end
            end
            // back substitution, unknown index in r_k, j in r_i
            S_BINIT: begin
                if (r_sing) begin
                    x_we = 1'b1; x_wa = SW'(r_k);
                    if (r_k == nn - IW'(1)) begin n_k = '0; n_sub = '0; n_state = S_EMIT; end
                    else n_k = r_k + IW'(1);
                end else begin
                    w_ra = '0; u_ra = adr(CW'(r_k), CW'(nn));
                    n_ph = 1'b0; n_i = r_k + IW'(1); n_sub = '0; n_state = S_BACC;
                end
            end
            S_BACC: begin
                o_init = $signed(u_rd);
                u_ra = adr(CW'(r_k), CW'(r_i));
                x_ra = SW'(r_i);
                o_a = $signed(u_rd); o_b = $signed(x_rd);
                if (!r_ph) begin
                    o_cmd.acc_load = 1'b1; n_ph = 1'b1;
                end else if (r_i == nn) begin
                    if (!i_sts.busy_dp) n_state = S_BWR;
                end else if (r_sub == 2'd0) n_sub = 2'd1;
                else if (r_sub == 2'd1) begin
                    o_cmd.op = OP_MAC; n_sub = 2'd2;
                end else if (!i_sts.busy_dp) begin
                    n_i = r_i + IW'(1); n_sub = '0;
                end
            end
            S_BWR: begin
                x_we = 1'b1; x_wa = SW'(r_k);
                if (r_k == '0) begin n_state = S_EMIT; n_sub = '0; end
                else begin n_k = r_k - IW'(1); n_state = S_BINIT; end
            end
            S_EMIT: begin
                x_ra = SW'(r_k);
                if (r_sub == 2'd0) begin
                    n_sub = 2'd1;
                end else begin
                    x_ra = SW'(r_k + IW'(1));
                    o_valid = 1'b1;
                    if (r_k == nn - IW'(1)) begin
                        n_state = S_LOAD; n_row = '0; n_col = '0;
                    end else n_k = r_k + IW'(1);
                end
            end
            default: n_state = S_LOAD;
        endcase
    end
endmodule
`default_nettype wire

// ----- src/crout_lu_linear_solver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Signals                          | Handshake
// request   | i_start, o_busy, i_req           | taken when i_start & !o_busy
// result    | o_valid, o_res                   | one cycle, no back-pressure
// config    | i_cfg_we, i_cfg_data             | written on any clock edge with i_cfg_we high
//
// Loading takes one cycle per request. After the final coefficient the block
// fills missing entries with zero, factors, back-substitutes and emits n
// results on consecutive cycles. Each multiply-accumulate steps through read,
// issue and product wait, and each division runs on a serial 48-bit divider.
// Synchronous active-low reset; order resets to 3.
module crout_lu_linear_solver import crout_pkg::*; #(
    parameter int unsigned MaxOrder = DefMaxOrder
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire t_in_req         i_req,
    output logic                 o_busy,
    input  wire logic            i_cfg_we,
    input  wire logic [CfgW-1:0] i_cfg_data,
    output logic                 o_valid,
    output t_out_req             o_res
);
    t_cmd cmd;
    t_sts sts;
    logic signed [31:0] a, b, init, acc;

    crout_ctrl #(.MaxOrder(MaxOrder)) u_ctrl (
        .i_clk, .i_rst_n, .i_start, .i_req, .i_cfg_we, .i_cfg_data,
        .i_sts(sts), .i_acc(acc), .o_cmd(cmd), .o_a(a), .o_b(b), .o_init(init),
        .o_busy, .o_valid, .o_res);

    crout_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_a(a), .i_b(b), .i_init(init),
        .o_sts(sts), .o_acc(acc));

    // no result while a request could be taken
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> !o_valid) else $error("result while idle");
    // singular results carry zero
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.singular) |-> (o_res.solution_value == 32'sd0))
        else $error("singular value nonzero");
    // after last result, block idles
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.last_solution) |=> !o_busy) else $error("no return to idle");
endmodule
`default_nettype wire
